[sv/itr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types, constants and helpers for the integer to radix text converter.
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam int MAX_BASE_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int ALPHA_W         = 128;
  localparam int CFG_DATA_W      = 64;
  localparam int LEN_W           = 5;
  localparam int DIGIT_W         = 4;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  typedef enum logic [1:0] {
    REG_DIGITS_LOW  = 2'd0,
    REG_DIGITS_HIGH = 2'd1,
    REG_BASE_LEN    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               busy;
    logic               dig_valid;
    logic [DIGIT_W-1:0] dig;
  } div_stat_t;

  typedef struct packed {
    logic busy;
    logic ok;
  } abc_stat_t;

  function automatic logic [7:0] alpha_char(input logic [ALPHA_W-1:0] alpha,
                                            input logic [DIGIT_W-1:0] k);
    return alpha[k*8 +: 8];
  endfunction

endpackage
`default_nettype wire

[sv/itr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itr_if
// Valid/ready channels: number input, character output and register writes.
// ----------------------------------------------------------------------------
interface itr_in_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itr_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface itr_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/integer_to_radix_digits.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Signed integer to text in a configurable radix and digit alphabet.
// ----------------------------------------------------------------------------
// One number is taken at a time. After acceptance the bit-serial divider
// shifts through all VALUE_WIDTH quotient bits per digit (least significant
// digit first, stored in a small digit stack) while the alphabet checker
// walks all MAX_BASE positions alongside; conversion ends when both are
// done. Unless stalled, characters leave at one per cycle (sign first
// for negatives, digits most significant first, last_char on the final one).
// A number is dropped with no output if base_length is outside 2..MAX_BASE
// (then the input is free again on the next cycle) or if the alphabet holds
// a zero byte, '-', '+' or a repeated character. Register writes are taken
// at any time but must only be issued while no number is in progress.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
  parameter int VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_BASE    = itr_pkg::MAX_BASE_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  itr_in_if.sink    in_ch,
  itr_out_if.source out_ch,
  itr_cfg_if.sink   cfg_ch
);
  import itr_pkg::*;

  localparam int PW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int NW = $clog2(VALUE_WIDTH + 1);

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0]  digits_low_r, digits_high_r;
  logic [LEN_W-1:0]       base_len_r;
  logic [ALPHA_W-1:0]     alpha;

  logic                   neg_r;
  logic [NW-1:0]          nd_r;
  logic [PW-1:0]          rd_ptr_r;
  logic [DIGIT_W-1:0]     digit_mem [VALUE_WIDTH];

  logic                   out_valid_r;
  logic [7:0]             out_char_r;
  logic                   out_last_r;

  logic                   in_acc, len_ok, start, out_free;
  logic                   conv_done, load_sign, load_dig;
  logic [VALUE_WIDTH-1:0] raw, mag;

  div_stat_t div_stat;
  abc_stat_t abc_stat;

  assign alpha    = {digits_high_r, digits_low_r};
  assign raw      = in_ch.value;
  assign mag      = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign len_ok   = (base_len_r >= LEN_W'(2)) && (base_len_r <= LEN_W'(MAX_BASE));
  assign start    = in_acc && len_ok;
  assign out_free = !out_valid_r || out_ch.ready;
  assign conv_done = !div_stat.busy && !abc_stat.busy;

  itr_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mag   (mag),
    .radix (base_len_r),
    .stat  (div_stat)
  );

  itr_abc #(
    .MAX_BASE(MAX_BASE)
  ) u_abc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .alpha (alpha),
    .len   (base_len_r),
    .stat  (abc_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) begin
          if (!abc_stat.ok) state_nxt = ST_IDLE;
          else if (neg_r)   state_nxt = ST_SIGN;
          else              state_nxt = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (rd_ptr_r == '0)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    load_sign   = 1'b0;
    load_dig    = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SIGN: load_sign   = out_free;
      ST_EMIT: load_dig    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      digits_low_r  <= '0;
      digits_high_r <= '0;
      base_len_r    <= '0;
      out_valid_r   <= 1'b0;
      nd_r          <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_DIGITS_LOW:  digits_low_r  <= cfg_ch.data;
          REG_DIGITS_HIGH: digits_high_r <= cfg_ch.data;
          REG_BASE_LEN:    base_len_r    <= cfg_ch.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (load_sign || load_dig) out_valid_r <= 1'b1;
      else if (out_ch.ready)     out_valid_r <= 1'b0;
      if (start)                   nd_r <= '0;
      else if (div_stat.dig_valid) nd_r <= nd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) neg_r <= raw[VALUE_WIDTH-1];
    if (div_stat.dig_valid) digit_mem[nd_r[PW-1:0]] <= div_stat.dig;
    if (state_r == ST_CONV) rd_ptr_r <= PW'(nd_r - 1'b1);
    else if (load_dig)      rd_ptr_r <= rd_ptr_r - 1'b1;
    if (load_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (load_dig) begin
      out_char_r <= alpha_char(alpha, digit_mem[rd_ptr_r]);
      out_last_r <= (rd_ptr_r == '0);
    end
  end

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.text_char = out_char_r;
  assign out_ch.last_char = out_last_r;

endmodule
`default_nettype wire

[sv/itr_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itr_div
// Bit-serial restoring divider: one quotient bit per cycle, one digit per
// full pass over VALUE_WIDTH bits, repeated on the quotient until it is zero.
// ----------------------------------------------------------------------------
module itr_div #(
  parameter int VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [VALUE_WIDTH-1:0]        mag,
  input  wire logic [itr_pkg::LEN_W-1:0]     radix,
  output itr_pkg::div_stat_t                 stat
);
  import itr_pkg::*;

  localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  logic                   busy_r, busy_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt, rem_step;
  logic [LEN_W-1:0]       trial, trial_sub;
  logic                   ge, digit_end;

  always_comb begin
    trial     = {rem_r, q_r[VALUE_WIDTH-1]};
    ge        = (trial >= radix);
    trial_sub = trial - radix;
    rem_step  = ge ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    digit_end = busy_r && (cnt_r == CW'(VALUE_WIDTH - 1));

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = mag;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt = {q_r[VALUE_WIDTH-2:0], ge};
      if (digit_end) begin
        cnt_nxt  = '0;
        rem_nxt  = '0;
        busy_nxt = (q_nxt != '0);
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        rem_nxt = rem_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy      = busy_r;
  assign stat.dig_valid = digit_end;
  assign stat.dig       = rem_step;

endmodule
`default_nettype wire

[sv/itr_abc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itr_abc
// Alphabet checker: walks the characters one per cycle, flagging reserved
// bytes and any repeat of the current character further up the alphabet.
// ----------------------------------------------------------------------------
module itr_abc #(
  parameter int MAX_BASE = itr_pkg::MAX_BASE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [itr_pkg::ALPHA_W-1:0]   alpha,
  input  wire logic [itr_pkg::LEN_W-1:0]     len,
  output itr_pkg::abc_stat_t                 stat
);
  import itr_pkg::*;

  localparam int IW = $clog2(MAX_BASE);

  logic          busy_r, busy_nxt;
  logic          err_r, err_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [7:0]    cur;
  logic          active, bad, dup;

  always_comb begin
    cur    = alpha_char(alpha, DIGIT_W'(idx_r));
    active = (LEN_W'(idx_r) < len);
    bad    = active && ((cur == 8'h00) || (cur == CHAR_MINUS) || (cur == CHAR_PLUS));
    dup    = 1'b0;
    for (int b = 0; b < MAX_BASE; b++) begin
      if ((DIGIT_W'(b) > DIGIT_W'(idx_r)) && (LEN_W'(b) < len) &&
          (alpha_char(alpha, DIGIT_W'(b)) == cur)) begin
        dup = 1'b1;
      end
    end

    busy_nxt = busy_r;
    err_nxt  = err_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      err_nxt  = 1'b0;
      idx_nxt  = '0;
    end else if (busy_r) begin
      err_nxt = err_r | bad | dup;
      if (idx_r == IW'(MAX_BASE - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      err_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      err_r  <= err_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.ok   = !err_r;

endmodule
`default_nettype wire

[sv/itr_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itr_chk
// Port-level checks for the radix converter, bound to the top level.
// ----------------------------------------------------------------------------
module itr_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_text_char,
  input wire logic       out_last_char
);
  import itr_pkg::*;

  // stalled output transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_char) && $stable(out_last_char))
    else $error("output payload changed while stalled");

  // a sign never closes a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_text_char == CHAR_MINUS) |-> !out_last_char)
    else $error("minus sign marked as final character");

  // input only free once the pending character is the final one
  a_ready_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last_char)
    else $error("input ready while a number is still being sent");

  // characters of one number follow without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_char |=> out_valid)
    else $error("gap inside a number's characters");

endmodule

bind integer_to_radix_digits itr_chk u_itr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_text_char (out_ch.text_char),
  .out_last_char (out_ch.last_char)
);
`default_nettype wire
